FILE: src/ccr_pkg.sv
`timescale 1ns / 1ps
package ccr_pkg;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_HORIZ = 2'd1;
  localparam logic [1:0] ST_SAME  = 2'd2;
  localparam logic [1:0] ST_SMALL = 2'd3;

  localparam int QDEPTH     = 4;
  localparam int QAW        = $clog2(QDEPTH);
  localparam int DIV_STEPS  = 64;
  localparam int ROOT_STEPS = 32;

  typedef struct packed {
    logic signed [31:0] first_x;
    logic signed [31:0] first_y;
    logic signed [31:0] second_x;
    logic signed [31:0] second_y;
    logic        [30:0] radius;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] center_a_x;
    logic signed [31:0] center_a_y;
    logic signed [31:0] center_b_x;
    logic signed [31:0] center_b_y;
    logic        [1:0]  status;
  } out_item_t;

  typedef struct packed {
    logic signed [31:0] mx;
    logic signed [31:0] my;
    logic [1:0]         status;
    logic               neg;
    logic               dxz;
  } side_t;

  typedef struct packed {
    side_t       side;
    logic [63:0] sq;
    logic [63:0] h;
    logic [63:0] d;
  } job_t;

endpackage

FILE: src/ccr_queue.sv
`timescale 1ns / 1ps
module ccr_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  ccr_pkg::job_t wdata,
  output logic          full,
  input  logic          pop,
  output logic          empty,
  output ccr_pkg::job_t rdata
);

  ccr_pkg::job_t                 mem_r [ccr_pkg::QDEPTH];
  logic [ccr_pkg::QAW-1:0]       wp_r;
  logic [ccr_pkg::QAW-1:0]       rp_r;
  logic [ccr_pkg::QAW:0]         cnt_r;
  logic [ccr_pkg::QAW:0]         cnt_nxt;
  logic                          do_push;
  logic                          do_pop;

  assign full    = (cnt_r == (ccr_pkg::QAW+1)'(ccr_pkg::QDEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) begin
        wp_r <= wp_r + 1'b1;
      end
      if (do_pop) begin
        rp_r <= rp_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= wdata;
    end
  end

endmodule

FILE: src/ccr_front.sv
`timescale 1ns / 1ps
module ccr_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  output logic              full,
  input  ccr_pkg::in_item_t in_data,
  output logic              q_push,
  output ccr_pkg::job_t     q_data,
  input  logic              q_full
);

  logic fe;
  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;

  ccr_pkg::in_item_t a1_r;

  logic signed [32:0] dx2_r, dy2_r;
  logic signed [31:0] mx2_r, my2_r;
  logic [30:0]        r2_r;

  logic [31:0]        u3_r, v3u_r;
  logic               dxz3_r, dyz3_r, neg3_r;
  logic signed [31:0] mx3_r, my3_r;
  logic [30:0]        r3_r;

  logic [63:0]        u4_r, v4sq_r, lim4_r;
  logic               dxz4_r, dyz4_r, neg4_r;
  logic signed [31:0] mx4_r, my4_r;

  logic [64:0]        ds5_r;
  logic [63:0]        v5sq_r, lim5_r;
  logic               dxz5_r, dyz5_r, neg5_r;
  logic signed [31:0] mx5_r, my5_r;

  ccr_pkg::job_t      j6_r;

  logic [32:0] sx_nxt, sy_nxt;
  logic [32:0] dx_nxt, dy_nxt;
  logic [32:0] nx_nxt, ny_nxt;
  logic [61:0] rr_nxt;
  logic [65:0] diff_nxt;
  logic [1:0]  st_nxt;

  assign fe     = !(v6_r && q_full);
  assign full   = !fe;
  assign q_push = v6_r;
  assign q_data = j6_r;

  assign sx_nxt = {a1_r.first_x[31], a1_r.first_x} + {a1_r.second_x[31], a1_r.second_x};
  assign sy_nxt = {a1_r.first_y[31], a1_r.first_y} + {a1_r.second_y[31], a1_r.second_y};
  assign dx_nxt = {a1_r.second_x[31], a1_r.second_x} - {a1_r.first_x[31], a1_r.first_x};
  assign dy_nxt = {a1_r.second_y[31], a1_r.second_y} - {a1_r.first_y[31], a1_r.first_y};
  assign nx_nxt = -dx2_r;
  assign ny_nxt = -dy2_r;
  assign rr_nxt = {31'b0, r3_r} * {31'b0, r3_r};
  assign diff_nxt = {2'b0, lim5_r} - {1'b0, ds5_r};

  always_comb begin
    st_nxt = ccr_pkg::ST_OK;
    if (dxz5_r && dyz5_r) begin
      st_nxt = ccr_pkg::ST_SAME;
    end else if (dyz5_r) begin
      st_nxt = ccr_pkg::ST_HORIZ;
    end else if (diff_nxt[65]) begin
      st_nxt = ccr_pkg::ST_SMALL;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else if (fe) begin
      v1_r <= push;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fe) begin
      a1_r   <= in_data;

      dx2_r  <= dx_nxt;
      dy2_r  <= dy_nxt;
      mx2_r  <= sx_nxt[32:1];
      my2_r  <= sy_nxt[32:1];
      r2_r   <= a1_r.radius;

      u3_r   <= dx2_r[32] ? nx_nxt[31:0] : dx2_r[31:0];
      v3u_r  <= dy2_r[32] ? ny_nxt[31:0] : dy2_r[31:0];
      dxz3_r <= (dx2_r == '0);
      dyz3_r <= (dy2_r == '0);
      neg3_r <= dx2_r[32] ^ dy2_r[32];
      mx3_r  <= mx2_r;
      my3_r  <= my2_r;
      r3_r   <= r2_r;

      u4_r   <= {32'b0, u3_r} * {32'b0, u3_r};
      v4sq_r <= {32'b0, v3u_r} * {32'b0, v3u_r};
      lim4_r <= {rr_nxt, 2'b00};
      dxz4_r <= dxz3_r;
      dyz4_r <= dyz3_r;
      neg4_r <= neg3_r;
      mx4_r  <= mx3_r;
      my4_r  <= my3_r;

      ds5_r  <= {1'b0, u4_r} + {1'b0, v4sq_r};
      v5sq_r <= v4sq_r;
      lim5_r <= lim4_r;
      dxz5_r <= dxz4_r;
      dyz5_r <= dyz4_r;
      neg5_r <= neg4_r;
      mx5_r  <= mx4_r;
      my5_r  <= my4_r;

      j6_r.side.mx     <= mx5_r;
      j6_r.side.my     <= my5_r;
      j6_r.side.status <= st_nxt;
      j6_r.side.neg    <= neg5_r;
      j6_r.side.dxz    <= dxz5_r;
      j6_r.sq          <= v5sq_r;
      j6_r.h           <= diff_nxt[63:0];
      j6_r.d           <= ds5_r[63:0];
    end
  end

endmodule

FILE: src/ccr_root.sv
`timescale 1ns / 1ps
module ccr_root (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] n_in,
  output logic [31:0] root
);

  logic [63:0] n_r   [ccr_pkg::ROOT_STEPS];
  logic [63:0] res_r [ccr_pkg::ROOT_STEPS];

  for (genvar k = 0; k < ccr_pkg::ROOT_STEPS; k++) begin : g_step
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
    logic [63:0] n_in_k;
    logic [63:0] res_in_k;
    logic [63:0] t;
    logic        ge;

    if (k == 0) begin : g_first
      assign n_in_k   = n_in;
      assign res_in_k = '0;
    end else begin : g_rest
      assign n_in_k   = n_r[k-1];
      assign res_in_k = res_r[k-1];
    end

    assign t  = res_in_k + BIT;
    assign ge = (n_in_k >= t);

    always_ff @(posedge clk) begin
      if (en) begin
        n_r[k]   <= ge ? (n_in_k - t) : n_in_k;
        res_r[k] <= ge ? ((res_in_k >> 1) + BIT) : (res_in_k >> 1);
      end
    end
  end

  assign root = res_r[ccr_pkg::ROOT_STEPS-1][31:0];

endmodule

FILE: src/ccr_back.sv
`timescale 1ns / 1ps
module ccr_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  input  ccr_pkg::job_t      q_data,
  output logic               q_pop,
  output logic               empty,
  input  logic               pop,
  output ccr_pkg::out_item_t out_data
);

  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    logic signed [31:0] s;
    if (v > 34'sd2147483647) begin
      s = 32'sh7fffffff;
    end else if (v < -34'sd2147483648) begin
      s = 32'sh80000000;
    end else begin
      s = v[31:0];
    end
    return s;
  endfunction

  logic en;

  logic          mv_r;
  ccr_pkg::job_t mj_r;
  logic [63:0]   p00_r, p01_r, p10_r, p11_r;

  logic          sv_r;
  ccr_pkg::job_t sj_r;
  logic [63:0]   hi_r, lo_r;
  logic [127:0]  prod_nxt;

  logic          dv_r  [ccr_pkg::DIV_STEPS];
  ccr_pkg::job_t dj_r  [ccr_pkg::DIV_STEPS];
  logic [63:0]   rem_r [ccr_pkg::DIV_STEPS];
  logic [63:0]   num_r [ccr_pkg::DIV_STEPS];
  logic [63:0]   quo_r [ccr_pkg::DIV_STEPS];

  logic           yv_r;
  ccr_pkg::side_t yside_r;
  logic [63:0]    qx_r, qy_r;

  logic           rv_r    [ccr_pkg::ROOT_STEPS];
  ccr_pkg::side_t rside_r [ccr_pkg::ROOT_STEPS];
  logic [31:0]    rx, ry;

  logic           ov_r;
  ccr_pkg::side_t oside_r;
  logic [31:0]    ox_r, oy_r;
  logic [32:0]    ox_nxt, oy_nxt;

  logic               out_valid_r;
  ccr_pkg::out_item_t out_r;
  logic signed [33:0] mx_w, my_w, ox_w, oy_w;
  logic signed [33:0] ax_w, bx_w, yp_w, ym_w;

  assign en       = !out_valid_r || pop;
  assign q_pop    = en && !q_empty;
  assign empty    = !out_valid_r;
  assign out_data = out_r;

  assign prod_nxt = {p11_r, p00_r} + {32'b0, p01_r, 32'b0} + {32'b0, p10_r, 32'b0};

  always_ff @(posedge clk) begin
    if (en) begin
      mj_r  <= q_data;
      p00_r <= {32'b0, q_data.sq[31:0]}  * {32'b0, q_data.h[31:0]};
      p01_r <= {32'b0, q_data.sq[31:0]}  * {32'b0, q_data.h[63:32]};
      p10_r <= {32'b0, q_data.sq[63:32]} * {32'b0, q_data.h[31:0]};
      p11_r <= {32'b0, q_data.sq[63:32]} * {32'b0, q_data.h[63:32]};
      sj_r  <= mj_r;
      hi_r  <= prod_nxt[127:64];
      lo_r  <= prod_nxt[63:0];
    end
  end

  for (genvar k = 0; k < ccr_pkg::DIV_STEPS; k++) begin : g_div
    logic          v_in;
    ccr_pkg::job_t j_in;
    logic [63:0]   rem_in, num_in, quo_in;
    logic [64:0]   t;
    logic [64:0]   t_sub;
    logic          ge;

    if (k == 0) begin : g_first
      assign v_in   = sv_r;
      assign j_in   = sj_r;
      assign rem_in = hi_r;
      assign num_in = lo_r;
      assign quo_in = '0;
    end else begin : g_rest
      assign v_in   = dv_r[k-1];
      assign j_in   = dj_r[k-1];
      assign rem_in = rem_r[k-1];
      assign num_in = num_r[k-1];
      assign quo_in = quo_r[k-1];
    end

    assign t     = {rem_in, num_in[63]};
    assign ge    = (t >= {1'b0, j_in.d});
    assign t_sub = t - {1'b0, j_in.d};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[k] <= 1'b0;
      end else if (en) begin
        dv_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dj_r[k]  <= j_in;
        rem_r[k] <= ge ? t_sub[63:0] : t[63:0];
        num_r[k] <= {num_in[62:0], 1'b0};
        quo_r[k] <= {quo_in[62:0], ge};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      yside_r <= dj_r[ccr_pkg::DIV_STEPS-1].side;
      qx_r    <= quo_r[ccr_pkg::DIV_STEPS-1];
      qy_r    <= dj_r[ccr_pkg::DIV_STEPS-1].h - quo_r[ccr_pkg::DIV_STEPS-1]
                 - {63'b0, (rem_r[ccr_pkg::DIV_STEPS-1] != '0)};
    end
  end

  ccr_root u_root_x (
    .clk  (clk),
    .en   (en),
    .n_in (qx_r),
    .root (rx)
  );

  ccr_root u_root_y (
    .clk  (clk),
    .en   (en),
    .n_in (qy_r),
    .root (ry)
  );

  for (genvar k = 0; k < ccr_pkg::ROOT_STEPS; k++) begin : g_side
    logic           v_in;
    ccr_pkg::side_t s_in;

    if (k == 0) begin : g_first
      assign v_in = yv_r;
      assign s_in = yside_r;
    end else begin : g_rest
      assign v_in = rv_r[k-1];
      assign s_in = rside_r[k-1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        rv_r[k] <= 1'b0;
      end else if (en) begin
        rv_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rside_r[k] <= s_in;
      end
    end
  end

  assign ox_nxt = {1'b0, rx} + 33'd1;
  assign oy_nxt = {1'b0, ry} + 33'd1;

  always_ff @(posedge clk) begin
    if (en) begin
      oside_r <= rside_r[ccr_pkg::ROOT_STEPS-1];
      ox_r    <= ox_nxt[32:1];
      oy_r    <= rside_r[ccr_pkg::ROOT_STEPS-1].dxz ? '0 : oy_nxt[32:1];
    end
  end

  assign mx_w = {{2{oside_r.mx[31]}}, oside_r.mx};
  assign my_w = {{2{oside_r.my[31]}}, oside_r.my};
  assign ox_w = {2'b00, ox_r};
  assign oy_w = {2'b00, oy_r};
  assign ax_w = mx_w + ox_w;
  assign bx_w = mx_w - ox_w;
  assign yp_w = my_w + oy_w;
  assign ym_w = my_w - oy_w;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mv_r        <= 1'b0;
      sv_r        <= 1'b0;
      yv_r        <= 1'b0;
      ov_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      mv_r        <= !q_empty;
      sv_r        <= mv_r;
      yv_r        <= dv_r[ccr_pkg::DIV_STEPS-1];
      ov_r        <= rv_r[ccr_pkg::ROOT_STEPS-1];
      out_valid_r <= ov_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r.status <= oside_r.status;
      if (oside_r.status != ccr_pkg::ST_OK) begin
        out_r.center_a_x <= '0;
        out_r.center_a_y <= '0;
        out_r.center_b_x <= '0;
        out_r.center_b_y <= '0;
      end else begin
        out_r.center_a_x <= sat32(ax_w);
        out_r.center_b_x <= sat32(bx_w);
        out_r.center_a_y <= sat32(oside_r.neg ? yp_w : ym_w);
        out_r.center_b_y <= sat32(oside_r.neg ? ym_w : yp_w);
      end
    end
  end

endmodule

FILE: src/circle_centers_from_chord_radius.sv
`timescale 1ns / 1ps
// Returns the two centers of the circles of a given radius through two points, all in
// signed fixed point, with a status code for horizontal chords, identical points and a
// radius too small. While neither end stalls, the block takes one pair of points per
// cycle and returns one result per item in order. The back end holds a 64-step
// restoring divider followed by two 32-step square root pipelines that run side by side.
// The front end classifies items and feeds a four-entry queue, so either end may stall
// alone.
module circle_centers_from_chord_radius (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  ccr_pkg::in_item_t  in_data,
  output logic               empty,
  input  logic               pop,
  output ccr_pkg::out_item_t out_data
);

  logic          q_push;
  logic          q_full;
  logic          q_pop;
  logic          q_empty;
  ccr_pkg::job_t q_wdata;
  ccr_pkg::job_t q_rdata;

  ccr_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .full    (full),
    .in_data (in_data),
    .q_push  (q_push),
    .q_data  (q_wdata),
    .q_full  (q_full)
  );

  ccr_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .empty (q_empty),
    .rdata (q_rdata)
  );

  ccr_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_empty),
    .q_data   (q_rdata),
    .q_pop    (q_pop),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data)
  );

endmodule

FILE: src/ccr_checker.sv
`timescale 1ns / 1ps
module ccr_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               empty,
  input logic               pop,
  input ccr_pkg::out_item_t out_data
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("result queue not empty after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && !pop |=> !empty && $stable(out_data))
    else $error("waiting result changed before it was taken");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && out_data.status != ccr_pkg::ST_OK |->
      out_data.center_a_x == 0 && out_data.center_a_y == 0 &&
      out_data.center_b_x == 0 && out_data.center_b_y == 0)
    else $error("flagged result carries nonzero centers");

  a_order_x: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && out_data.status == ccr_pkg::ST_OK |->
      out_data.center_a_x >= out_data.center_b_x)
    else $error("first center does not have the larger x");

endmodule

bind circle_centers_from_chord_radius ccr_checker u_chk (.*);

FILE: tb/sv/circle_centers_from_chord_radius_tb.sv
`timescale 1ns / 1ps
module circle_centers_from_chord_radius_tb;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 300;
  localparam int RANDOM_ITEMS   = 1830;

  logic               clk;
  logic               rst_n;
  logic               push;
  logic               full;
  ccr_pkg::in_item_t  in_data;
  logic               empty;
  logic               pop;
  ccr_pkg::out_item_t out_data;

  ccr_pkg::out_item_t centers_due[$];
  int                 errors;
  int                 idle_cycles;
  int                 pop_wait;
  bit                 quiet;

  circle_centers_from_chord_radius uut (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full), .in_data(in_data),
    .empty(empty), .pop(pop), .out_data(out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [63:0] root_floor(logic [63:0] n);
    logic [63:0]  res;
    logic [63:0]  t;
    logic [127:0] sq;
    res = '0;
    for (int i = 31; i >= 0; i--) begin
      t  = res | (64'd1 << i);
      sq = t * t;
      if (sq <= {64'd0, n}) begin
        res = t;
      end
    end
    return res;
  endfunction

  function automatic longint bisector_offset(logic [63:0] sq, logic [63:0] h,
                                             logic [63:0] d);
    logic [127:0] prod;
    logic [127:0] q;
    prod = {64'd0, sq} * {64'd0, h};
    q    = prod / {64'd0, d};
    return longint'((root_floor(q[63:0]) + 64'd1) >> 1);
  endfunction

  function automatic logic [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) begin
      return 32'h7FFF_FFFF;
    end
    if (v < -64'sd2147483648) begin
      return 32'h8000_0000;
    end
    return v[31:0];
  endfunction

  function automatic ccr_pkg::out_item_t circle_centers(ccr_pkg::in_item_t it);
    ccr_pkg::out_item_t r;
    longint             x1, y1, x2, y2, dx, dy, mx, my, ox, oy, s;
    logic [63:0]        u, v, u2, v2, lim, h;
    logic [64:0]        dsum;
    x1 = longint'($signed(it.first_x));
    y1 = longint'($signed(it.first_y));
    x2 = longint'($signed(it.second_x));
    y2 = longint'($signed(it.second_y));
    dx = x2 - x1;
    dy = y2 - y1;
    u  = (dx < 0) ? -dx : dx;
    v  = (dy < 0) ? -dy : dy;
    u2 = u * u;
    v2 = v * v;
    dsum = {1'b0, u2} + {1'b0, v2};
    lim  = 64'd4 * {33'd0, it.radius} * {33'd0, it.radius};
    r = '0;
    if (dx == 0 && dy == 0) begin
      r.status = ccr_pkg::ST_SAME;
    end else if (dy == 0) begin
      r.status = ccr_pkg::ST_HORIZ;
    end else if (dsum[64] || dsum[63:0] > lim) begin
      r.status = ccr_pkg::ST_SMALL;
    end else begin
      h  = lim - dsum[63:0];
      mx = (x1 + x2) >>> 1;
      my = (y1 + y2) >>> 1;
      ox = bisector_offset(v2, h, dsum[63:0]);
      oy = (dx == 0) ? 0 : bisector_offset(u2, h, dsum[63:0]);
      s  = ((dx < 0) != (dy < 0)) ? -1 : 1;
      r.center_a_x = clamp32(mx + ox);
      r.center_a_y = clamp32(my - s * oy);
      r.center_b_x = clamp32(mx - ox);
      r.center_b_y = clamp32(my + s * oy);
      r.status     = ccr_pkg::ST_OK;
    end
    return r;
  endfunction

  task automatic send_item(input logic [31:0] x1, input logic [31:0] y1,
                           input logic [31:0] x2, input logic [31:0] y2,
                           input logic [30:0] rad);
    int                gap;
    ccr_pkg::in_item_t it;
    it.first_x  = x1;
    it.first_y  = y1;
    it.second_x = x2;
    it.second_y = y2;
    it.radius   = rad;
    gap = quiet ? 0 : $urandom_range(0, 19);
    repeat (gap) begin
      @(negedge clk);
      push <= 1'b0;
    end
    @(negedge clk);
    push    <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (full);
    centers_due.push_back(circle_centers(it));
  endtask

  function automatic logic [31:0] scaled_value();
    return $signed($urandom) >>> $urandom_range(0, 31);
  endfunction

  task automatic test_directed();
    send_item(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 31'h7FFF_FFFF);
    send_item(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 31'h7FFF_FFFF);
    send_item(32'h0001_0000, 32'h0002_0000, 32'h0001_0000, 32'h0002_0000, 31'd0);
    send_item(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 31'h7FFF_FFFF);
    send_item(32'h0000_0000, 32'h0005_0000, 32'h0003_0000, 32'h0005_0000, 31'h0010_0000);
    send_item(32'h7FFF_FFFF, 32'h0000_0000, 32'h8000_0000, 32'h0000_0000, 31'h7FFF_FFFF);
    send_item(32'h0002_0000, 32'h0000_0000, 32'h0002_0000, 32'h0004_0000, 31'h0002_0000);
    send_item(32'h0002_0000, 32'h0004_0000, 32'h0002_0000, 32'h0000_0000, 31'h0005_0000);
    send_item(32'h0000_0000, 32'h0000_0000, 32'h0006_0000, 32'h0008_0000, 31'h0004_0000);
    send_item(32'h0000_0000, 32'h0000_0000, 32'h0006_0000, 32'h0008_0000, 31'h0005_0000);
    send_item(32'h0000_0000, 32'h0000_0000, 32'hFFFA_0000, 32'h0008_0000, 31'h0005_0000);
    send_item(32'h0000_0000, 32'h0000_0000, 32'h0000_0003, 32'h0000_0004, 31'd2);
    send_item(32'h0000_0000, 32'h0000_0000, 32'h0000_0001, 32'h0000_0001, 31'd0);
    send_item(32'h7FFF_0000, 32'h0000_0000, 32'h7FFF_0000, 32'h0001_0000, 31'h7FFF_FFFF);
    send_item(32'h8000_0000, 32'h0000_0000, 32'h8000_0000, 32'h0001_0000, 31'h7FFF_FFFF);
    send_item(32'h0000_0000, 32'h7FFF_0000, 32'h0001_0000, 32'h7FFF_8000, 31'h7FFF_FFFF);
    send_item(32'hFFFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'h7FFF_FFFF, 31'h7FFF_FFFF);
    send_item(32'h1234_5678, 32'h9ABC_DEF0, 32'h1234_5679, 32'h9ABC_DEF1, 31'h0000_0001);
  endtask

  task automatic test_random();
    logic [31:0] x1, y1, x2, y2, dx, dy;
    logic [30:0] rad;
    logic [63:0] chord_sq;
    longint      k;
    int          kind;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 150 == 0) begin
        quiet = ($urandom_range(0, 3) == 0);
      end
      kind = $urandom_range(0, 99);
      x1 = $signed($urandom) >>> 2;
      y1 = $signed($urandom) >>> 2;
      if (kind < 65) begin
        dx = scaled_value() >>> 2;
        dy = scaled_value() >>> 2;
        if ($urandom_range(0, 15) == 0) dx = '0;
        if ($urandom_range(0, 15) == 0) dy = '0;
        x2 = x1 + dx;
        y2 = y1 + dy;
        chord_sq = 64'($signed(dx) * $signed(dx)) + 64'($signed(dy) * $signed(dy));
        rad  = 31'((root_floor(chord_sq) >> 1) + 64'd1 + ($urandom >> $urandom_range(1, 31)));
      end else if (kind < 80) begin
        k  = $urandom_range(1, 1 << 26);
        x2 = x1 + 32'((($urandom_range(0, 1) != 0) ? -6 : 6) * k);
        y2 = y1 + 32'((($urandom_range(0, 1) != 0) ? -8 : 8) * k);
        rad = 31'(5 * k - $urandom_range(0, 1));
      end else begin
        x1 = $urandom;
        y1 = $urandom;
        x2 = ($urandom_range(0, 7) == 0) ? x1 : $urandom;
        y2 = ($urandom_range(0, 7) == 0) ? y1 : $urandom;
        rad = $urandom;
      end
      send_item(x1, y1, x2, y2, rad);
    end
    @(negedge clk);
    push <= 1'b0;
  endtask

  initial begin
    errors      = 0;
    quiet       = 1'b0;
    rst_n       = 1'b0;
    push        = 1'b0;
    in_data     = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    test_random();
    while (centers_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("circle_centers_from_chord_radius regression: pass");
    end else begin
      $display("circle_centers_from_chord_radius regression: fail");
    end
    $finish;
  end

  initial begin
    pop = 1'b0;
    forever begin
      @(negedge clk);
      pop <= rst_n && (pop_wait == 0);
    end
  end

  always @(posedge clk) begin
    ccr_pkg::out_item_t due;
    if (!rst_n) begin
      pop_wait    <= 0;
      idle_cycles <= 0;
    end else begin
      if ((push && !full) || (pop && !empty)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("circle_centers_from_chord_radius regression: fail");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (pop && !empty) begin
        pop_wait <= quiet ? 0 : $urandom_range(0, 19);
        if (centers_due.size() == 0) begin
          $display("%0t: result beat with nothing expected, actual %h", $time, out_data);
          errors++;
        end else begin
          due = centers_due.pop_front();
          if (out_data.center_a_x !== due.center_a_x) begin
            $display("%0t: center_a_x expected %h actual %h", $time, due.center_a_x,
                     out_data.center_a_x);
            errors++;
          end
          if (out_data.center_a_y !== due.center_a_y) begin
            $display("%0t: center_a_y expected %h actual %h", $time, due.center_a_y,
                     out_data.center_a_y);
            errors++;
          end
          if (out_data.center_b_x !== due.center_b_x) begin
            $display("%0t: center_b_x expected %h actual %h", $time, due.center_b_x,
                     out_data.center_b_x);
            errors++;
          end
          if (out_data.center_b_y !== due.center_b_y) begin
            $display("%0t: center_b_y expected %h actual %h", $time, due.center_b_y,
                     out_data.center_b_y);
            errors++;
          end
          if (out_data.status !== due.status) begin
            $display("%0t: status expected %0d actual %0d", $time, due.status,
                     out_data.status);
            errors++;
          end
        end
      end else if (pop_wait > 0) begin
        pop_wait <= pop_wait - 1;
      end
    end
  end

endmodule
